[hw/rtl/bvs_pkg.sv]
// Shared types and codes for the bounded vector store.
`default_nettype none

package bvs_pkg;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_GET    = 3'd3,
      OP_SET    = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_RESIZE = 3'd6
   } bvs_op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BOUND = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned POS_BITS  = 5;
   localparam int unsigned PORT_BITS = 64;

   typedef struct packed {
      logic load_value;
      logic load_left;
      logic read_sel;
   } bvs_cell_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/bvs_cell.sv]
// One storage cell of the vector store: holds one entry, takes its left neighbor on insert.
`default_nettype none

module bvs_cell
   import bvs_pkg::*;
#(
   parameter int unsigned WORD_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bvs_cell_ctrl_type    ctrl,
   input  wire logic [WORD_BITS-1:0] value,
   input  wire logic [WORD_BITS-1:0] left_data,
   output logic      [WORD_BITS-1:0] entry_data,
   output logic      [WORD_BITS-1:0] read_data
);

   logic [WORD_BITS-1:0] entry_ff;
   logic [WORD_BITS-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_value) begin
         entry_in = value;
      end else if (ctrl.load_left) begin
         entry_in = left_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_data = entry_ff;
   assign read_data  = ctrl.read_sel ? entry_ff : '0;

endmodule

`default_nettype wire

[hw/rtl/bounded_vector_store_unit.sv]
// Top level of the bounded vector store: operation decode, length counter, cell row, result register.
// One operation is taken per cycle while req_stall is low; its result appears in the result register
// on the next cycle, and req_stall is high only while a result is held against rsp_stall. Entries
// live in a row of CAPACITY cells, one per entry; an insert moves every later entry up by one cell
// in the same cycle. Reset clears all cells and the length at once. Only the low WORD_BITS bits of
// a value are stored; read data is zero-extended to 64 bits.
`default_nettype none

module bounded_vector_store_unit
   import bvs_pkg::*;
#(
   parameter int unsigned CAPACITY  = 16,
   parameter int unsigned WORD_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_operation,
   input  wire logic [POS_BITS-1:0]  req_position,
   input  wire logic [PORT_BITS-1:0] req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [PORT_BITS-1:0]      rsp_read_data,
   output logic [POS_BITS-1:0]       rsp_length
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
   localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [PORT_BITS-1:0] rsp_read_data_ff;
   logic [POS_BITS-1:0]  rsp_length_ff;

   logic                 fire;
   bvs_op_type           op;
   logic [CMP_W-1:0]     cnt_ext;
   logic [CMP_W-1:0]     pos_ext;
   logic [CMP_W-1:0]     cnt_new;
   logic [1:0]           status_c;
   logic                 wr_en;
   logic                 ins_en;
   logic                 rd_en;
   logic [CMP_W-1:0]     wr_idx;
   logic [CMP_W-1:0]     rd_idx;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] store_value;

   bvs_cell_ctrl_type    cell_ctrl  [CAPACITY];
   logic [WORD_BITS-1:0] entry_data [CAPACITY];
   logic [WORD_BITS-1:0] cell_rd    [CAPACITY];
   logic [CAPACITY-1:0]  read_sel_vec;
   logic [CAPACITY-1:0]  load_value_vec;

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign fire        = req_valid && !req_stall;
   assign op          = bvs_op_type'(req_operation);
   assign cnt_ext     = CMP_W'(count_ff);
   assign pos_ext     = CMP_W'(req_position);
   assign store_value = req_value[WORD_BITS-1:0];

   always_comb begin
      status_c = ST_OK;
      cnt_new  = cnt_ext;
      wr_en    = 1'b0;
      ins_en   = 1'b0;
      rd_en    = 1'b0;
      wr_idx   = pos_ext;
      rd_idx   = pos_ext;
      unique case (op)
         OP_PUSH: begin
            if (cnt_ext >= CAP_EXT) begin
               status_c = ST_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_idx  = cnt_ext;
               cnt_new = cnt_ext + CMP_W'(1);
            end
         end
         OP_POP: begin
            if (cnt_ext == '0) begin
               status_c = ST_BOUND;
            end else begin
               rd_en   = 1'b1;
               rd_idx  = cnt_ext - CMP_W'(1);
               cnt_new = cnt_ext - CMP_W'(1);
            end
         end
         OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_c = ST_BOUND;
            end else if (cnt_ext >= CAP_EXT) begin
               status_c = ST_FULL;
            end else begin
               wr_en   = 1'b1;
               ins_en  = 1'b1;
               cnt_new = cnt_ext + CMP_W'(1);
            end
         end
         OP_GET: begin
            if (pos_ext >= cnt_ext || pos_ext >= CAP_EXT) begin
               status_c = ST_BOUND;
            end else begin
               rd_en = 1'b1;
            end
         end
         OP_SET: begin
            if (pos_ext >= cnt_ext || pos_ext >= CAP_EXT) begin
               status_c = ST_BOUND;
            end else begin
               wr_en = 1'b1;
            end
         end
         OP_CLEAR: begin
            cnt_new = '0;
         end
         OP_RESIZE: begin
            if (pos_ext > CAP_EXT) begin
               status_c = ST_FULL;
            end else begin
               cnt_new = pos_ext;
            end
         end
         default: begin
         end
      endcase
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
         logic [WORD_BITS-1:0] left;

         if (i == 0) begin : g_first
            assign left = '0;
         end else begin : g_next
            assign left = entry_data[i-1];
         end

         assign cell_ctrl[i].load_value = fire && wr_en && (wr_idx == IDX);
         assign cell_ctrl[i].load_left  = fire && ins_en && (IDX > pos_ext) && (IDX <= cnt_ext);
         assign cell_ctrl[i].read_sel   = rd_en && (rd_idx == IDX);
         assign read_sel_vec[i]         = cell_ctrl[i].read_sel;
         assign load_value_vec[i]       = cell_ctrl[i].load_value;

         bvs_cell #(
            .WORD_BITS (WORD_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[i]),
            .value      (store_value),
            .left_data  (left),
            .entry_data (entry_data[i]),
            .read_data  (cell_rd[i])
         );
      end
   endgenerate

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   assign count_in     = fire ? cnt_new[CNT_W-1:0] : count_ff;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff    <= status_c;
         rsp_read_data_ff <= PORT_BITS'(rd_word);
         rsp_length_ff    <= cnt_new[POS_BITS-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_length    = rsp_length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CAP_EXT)
      else $error("length counter beyond capacity");

   a_one_read: assert property (@(posedge clock) disable iff (reset)
      $onehot0(read_sel_vec))
      else $error("more than one cell selected for read");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_value_vec))
      else $error("more than one cell loads the value");

   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      fire && (op == OP_CLEAR) |=> rsp_valid_ff && (rsp_length_ff == '0) && (count_ff == '0))
      else $error("clear did not empty the store");

endmodule

`default_nettype wire

[test/bounded_vector_store_unit_test.sv]
// Self-checking testbench for bounded_vector_store_unit: directed and random operations against a shadow store.
`timescale 1ns / 100ps

module bounded_vector_store_unit_test;
   import bvs_pkg::*;

   localparam int unsigned DEPTH        = 16;
   localparam logic [2:0]  OP_UNUSED    = 3'd7;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam logic [63:0] ALL_ONES     = '1;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] read_data;
      logic [4:0]  length;
   } store_result_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [2:0]  req_operation = OP_PUSH;
   logic [4:0]  req_position  = '0;
   logic [63:0] req_value     = '0;
   logic        rsp_stall     = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_read_data;
   logic [4:0]  rsp_length;

   logic [63:0]      shadow_words [DEPTH];
   int unsigned      shadow_len;
   store_result_type expected_results[$];
   int unsigned      fail_count;
   int unsigned      cycle_count;
   int unsigned      burst_left;
   bit               gaps_enabled;
   logic [7:0]       stall_pattern;
   int unsigned      stall_step;

   bounded_vector_store_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_read_data (rsp_read_data),
      .rsp_length    (rsp_length)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver backpressure: a repeating random stall pattern, sometimes stalling throughout, often none at all
   always @(posedge clock) begin
      if (stall_step % 64 == 0) begin
         case ($urandom_range(0, 7))
            0, 1, 2: stall_pattern = 8'h00;
            3:       stall_pattern = 8'hFF;
            default: stall_pattern = 8'($urandom);
         endcase
      end
      rsp_stall <= stall_pattern[stall_step % 8];
      stall_step++;
   end

   function automatic store_result_type apply_store_op(input logic [2:0] op,
                                                       input logic [4:0] pos,
                                                       input logic [63:0] value);
      store_result_type r;
      int unsigned k;
      r.status    = ST_OK;
      r.read_data = '0;
      case (op)
         OP_PUSH: begin
            if (shadow_len >= DEPTH) r.status = ST_FULL;
            else begin
               shadow_words[shadow_len] = value;
               shadow_len++;
            end
         end
         OP_POP: begin
            if (shadow_len == 0) r.status = ST_BOUND;
            else begin
               shadow_len--;
               r.read_data = shadow_words[shadow_len];
            end
         end
         OP_INSERT: begin
            if (pos > shadow_len) r.status = ST_BOUND;
            else if (shadow_len >= DEPTH) r.status = ST_FULL;
            else begin
               for (k = shadow_len; k > pos; k--) shadow_words[k] = shadow_words[k-1];
               shadow_words[pos] = value;
               shadow_len++;
            end
         end
         OP_GET: begin
            if (pos >= shadow_len) r.status = ST_BOUND;
            else r.read_data = shadow_words[pos];
         end
         OP_SET: begin
            if (pos >= shadow_len) r.status = ST_BOUND;
            else shadow_words[pos] = value;
         end
         OP_CLEAR: shadow_len = 0;
         OP_RESIZE: begin
            if (pos > DEPTH) r.status = ST_FULL;
            else shadow_len = pos;
         end
         default: ;
      endcase
      r.length = shadow_len[4:0];
      return r;
   endfunction

   // called at a rising edge; returns at the edge where the transfer happened
   task automatic send_op(input logic [2:0] op, input logic [4:0] pos, input logic [63:0] value);
      int unsigned gap;
      bit taken;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_enabled) gap = $urandom_range(0, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value     <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      expected_results.push_back(apply_store_op(op, pos, value));
   endtask

   always @(negedge clock) begin
      store_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               fail_count++;
            end
            if (rsp_length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_length);
               fail_count++;
            end
         end
      end
   end

   task automatic test_empty_bounds();
      send_op(OP_POP, 5'd0, '0);
      send_op(OP_GET, 5'd0, '0);
      send_op(OP_SET, 5'd0, ALL_ONES);
      send_op(OP_GET, 5'd31, '0);
   endtask

   task automatic test_full_limits();
      send_op(OP_RESIZE, 5'd16, '0);
      send_op(OP_GET, 5'd15, '0);
      send_op(OP_PUSH, 5'd0, ALL_ONES);
      send_op(OP_INSERT, 5'd16, ALL_ONES);
      send_op(OP_INSERT, 5'd17, ALL_ONES);
      send_op(OP_RESIZE, 5'd17, '0);
      send_op(OP_RESIZE, 5'd31, '0);
      send_op(OP_SET, 5'd15, ALL_ONES);
      send_op(OP_GET, 5'd15, '0);
   endtask

   task automatic test_insert_shift();
      send_op(OP_CLEAR, 5'd0, '0);
      send_op(OP_PUSH, 5'd0, ALL_ONES);
      send_op(OP_PUSH, 5'd0, 64'h0);
      send_op(OP_INSERT, 5'd0, 64'hA5A5_5A5A_0F0F_F0F0);
      send_op(OP_INSERT, 5'd3, 64'h8000_0000_0000_0001);
      send_op(OP_INSERT, 5'd1, 64'h1234_5678_9ABC_DEF0);
      send_op(OP_GET, 5'd0, '0);
      send_op(OP_GET, 5'd4, '0);
      send_op(OP_POP, 5'd0, '0);
   endtask

   task automatic test_resize_keeps_contents();
      send_op(OP_RESIZE, 5'd8, '0);
      send_op(OP_GET, 5'd7, '0);
      send_op(OP_RESIZE, 5'd16, '0);
      send_op(OP_GET, 5'd15, '0);
      send_op(OP_UNUSED, 5'd31, ALL_ONES);
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned fill_bias);
      int unsigned n, w, sel;
      logic [2:0]  op;
      logic [4:0]  pos;
      logic [63:0] value;
      for (n = 0; n < count; n++) begin
         if (n % 50 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
         w = $urandom_range(0, 99 + fill_bias);
         if (w < 18 + fill_bias / 2)      op = OP_PUSH;
         else if (w < 32 + fill_bias)     op = OP_INSERT;
         else if (w < 47 + fill_bias)     op = OP_POP;
         else if (w < 62 + fill_bias)     op = OP_GET;
         else if (w < 74 + fill_bias)     op = OP_SET;
         else if (w < 86 + fill_bias)     op = OP_RESIZE;
         else if (w < 90 + fill_bias)     op = OP_CLEAR;
         else if (w < 92 + fill_bias)     op = OP_UNUSED;
         else                             op = OP_GET;
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            if (op == OP_RESIZE) pos = 5'($urandom_range(0, DEPTH));
            else if ((op == OP_GET || op == OP_SET) && shadow_len > 0)
               pos = 5'($urandom_range(0, shadow_len - 1));
            else pos = 5'($urandom_range(0, shadow_len));
         end else if (sel < 8) begin
            case ($urandom_range(0, 3))
               0:       pos = 5'(shadow_len);
               1:       pos = 5'(shadow_len + 1);
               2:       pos = 5'(DEPTH);
               default: pos = 5'(DEPTH + 1);
            endcase
         end else pos = 5'($urandom_range(0, 31));
         case ($urandom_range(0, 15))
            0:       value = ALL_ONES;
            1:       value = '0;
            default: value = {$urandom, $urandom};
         endcase
         send_op(op, pos, value);
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < DEPTH; i++) shadow_words[i] = '0;
      shadow_len   = 0;
      fail_count   = 0;
      burst_left   = 0;
      gaps_enabled = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_bounds();
      test_full_limits();
      test_insert_shift();
      test_resize_keeps_contents();
      test_random_traffic(450, 0);
      test_random_traffic(250, 40);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
